// ----- sv/iis_pkg.sv -----
// Shared types and register codes for the integral image stream core.
package iis_pkg;

  // Width of one integral value and of the source pixel
  localparam int SumW = 32;
  localparam int PixW = 8;

  // Configuration register file
  localparam int DimW = 11;
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Position flags of one pixel, passed from the position tracker onward
  typedef struct packed {
    logic first_row;
    logic eor;
    logic eof;
  } pos_flags_t;

endpackage

// ----- sv/iis_line_store.sv -----
// Line store of the previous row's integral values: one write and one registered read per cycle.
module iis_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [iis_pkg::SumW-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [iis_pkg::SumW-1:0] wr_data
);

  logic [iis_pkg::SumW-1:0] mem [DEPTH];

  // Write back the finished sum
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read; hold it while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/iis_position.sv -----
// Raster position tracker and running row sum for the incoming pixel.
module iis_position #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CW         = 10,
  parameter int RW         = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [iis_pkg::PixW-1:0] pixel,
  input  logic [iis_pkg::DimW-1:0] image_width,
  input  logic [iis_pkg::DimW-1:0] image_height,
  output logic [CW-1:0]            col,
  output logic [iis_pkg::SumW-1:0] rowsum,
  output iis_pkg::pos_flags_t      flags
);

  logic [CW-1:0]            column_count;
  logic [RW-1:0]            row_count;
  logic [iis_pkg::SumW-1:0] row_running_sum;
  logic [CW:0]              w_eff;
  logic [RW:0]              h_eff;

  // Clamp the dimensions into 1..MAX
  always_comb begin
    if (image_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(image_width);
    end
    if (image_height == '0) begin
      h_eff = (RW+1)'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(image_height);
    end
  end

  // Describe the current pixel
  always_comb begin
    col             = column_count;
    rowsum          = row_running_sum + iis_pkg::SumW'(pixel);
    flags.first_row = (row_count == '0);
    flags.eor       = ({1'b0, column_count} + (CW+1)'(1)) >= w_eff;
    flags.eof       = flags.eor && (({1'b0, row_count} + (RW+1)'(1)) >= h_eff);
  end

  // Advance the position on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      row_running_sum <= '0;
    end else if (accept) begin
      if (flags.eor) begin
        column_count    <= '0;
        row_running_sum <= '0;
        if (flags.eof) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + RW'(1);
        end
      end else begin
        column_count    <= column_count + CW'(1);
        row_running_sum <= rowsum;
      end
    end
  end

endmodule

// ----- sv/integral_image_stream_core.sv -----
// Top level of the streaming integral image (summed-area table) core.
// Takes one 8-bit pixel per clock in raster order, unless the input stalls, and returns one
// 32-bit summed-area value per pixel, modulo 2^32, flagged with end of row and end of frame.
// Sustained rate is one pixel per cycle while the output is not stalled. A result passes from
// the stage 1 register into the output register, where it is held until taken. Outside reset,
// the input stalls only when stage 1 is full and the output register holds a stalled result.
// The timing is set by the line store, a single memory of MAX_WIDTH words that takes at most
// one read (issued when the pixel is accepted) and one write-back (when stage 1 advances) per
// cycle; a pixel that reads the entry the previous pixel is writing gets the value forwarded.
// The line store needs no clearing pass: the first row of each frame ignores what it reads.
// Configuration writes are always taken and apply to the next accepted pixel.
module integral_image_stream_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [iis_pkg::PixW-1:0]    pixel,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [iis_pkg::SumW-1:0]    integral_sum,
  output logic                        end_of_row,
  output logic                        end_of_frame,
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [iis_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [iis_pkg::DimW-1:0]    cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [iis_pkg::DimW-1:0] image_width;
  logic [iis_pkg::DimW-1:0] image_height;

  logic                     accept;
  logic [CW-1:0]            p_col;
  logic [iis_pkg::SumW-1:0] p_rowsum;
  iis_pkg::pos_flags_t      p_flags;

  logic                     s1_valid;
  logic [CW-1:0]            s1_col;
  logic [iis_pkg::SumW-1:0] s1_rowsum;
  iis_pkg::pos_flags_t      s1_flags;
  logic                     s1_fwd;
  logic [iis_pkg::SumW-1:0] fwd_data;
  logic [iis_pkg::SumW-1:0] rd_data;
  logic [iis_pkg::SumW-1:0] s1_above;
  logic [iis_pkg::SumW-1:0] s1_sum;
  logic                     s1_adv;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= iis_pkg::DimW'(320);
      image_height <= iis_pkg::DimW'(240);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        iis_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        iis_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 moves whenever the output register is free or being emptied
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = rst || (s1_valid && !s1_adv);
  assign accept   = in_valid && !in_stall;

  iis_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CW        (CW),
    .RW        (RW)
  ) u_position (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel       (pixel),
    .image_width (image_width),
    .image_height(image_height),
    .col         (p_col),
    .rowsum      (p_rowsum),
    .flags       (p_flags)
  );

  iis_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW   (CW)
  ) u_line_store (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(p_col),
    .rd_data(rd_data),
    .wr_en  (s1_adv),
    .wr_addr(s1_col),
    .wr_data(s1_sum)
  );

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload; flag a read that collides with the write at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col    <= p_col;
      s1_rowsum <= p_rowsum;
      s1_flags  <= p_flags;
      s1_fwd    <= s1_adv && (s1_col == p_col);
      fwd_data  <= s1_sum;
    end
  end

  // Add the value above; the first row sees zero
  always_comb begin
    if (s1_flags.first_row) begin
      s1_above = '0;
    end else if (s1_fwd) begin
      s1_above = fwd_data;
    end else begin
      s1_above = rd_data;
    end
    s1_sum = s1_rowsum + s1_above;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      integral_sum <= s1_sum;
      end_of_row   <= s1_flags.eor;
      end_of_frame <= s1_flags.eof;
    end
  end

endmodule

// ----- sv/iis_checker.sv -----
// Port-level checks for the integral image stream core, bound to its top level.
module iis_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [iis_pkg::SumW-1:0] integral_sum,
  input logic                     end_of_row,
  input logic                     end_of_frame
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(integral_sum)
      && $stable(end_of_row) && $stable(end_of_frame))
    else $error("stalled result changed");

  // End of frame only on the last pixel of a row
  a_eof_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> end_of_row)
    else $error("end of frame without end of row");

  // A new result follows an accepted transaction
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without accepted pixel");

  // Accept while the output register is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind integral_image_stream_core iis_checker u_iis_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .integral_sum(integral_sum),
  .end_of_row  (end_of_row),
  .end_of_frame(end_of_frame)
);
